// File: hdl/ashl_pkg.sv
// Shared types and constants for the aged sample history lookup block.
package ashl_pkg;

   // Default history depth and the reset value of the minimum age register.
   localparam int unsigned HISTORY_DEPTH_DEFAULT = 64;
   localparam logic [31:0] MIN_AGE_RESET = 32'd5000;

   // Operation codes carried by a request word.
   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic push;
      logic start_query;
      logic scan;
      logic capture_hit;
      logic capture_miss;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hit;
      logic scan_over;
      logic rsp_free;
   } status_type;

endpackage

// File: hdl/ashl_ctrl.sv
// Controller state machine of the aged sample history lookup block.
module ashl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_operation,
   output logic                req_ready,
   input  ashl_pkg::status_type status,
   output ashl_pkg::cmd_type    cmd
);

   ashl_pkg::state_type state_ff;
   ashl_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ashl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ashl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_operation == ashl_pkg::OP_PUSH) begin
                  cmd.push = 1'b1;
               end else begin
                  cmd.start_query = 1'b1;
                  state_in        = ashl_pkg::ST_SCAN;
               end
            end
         end
         ashl_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.hit) begin
               cmd.capture_hit = 1'b1;
               state_in        = ashl_pkg::ST_DONE;
            end else if (status.scan_over) begin
               cmd.capture_miss = 1'b1;
               state_in         = ashl_pkg::ST_DONE;
            end
         end
         ashl_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ashl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ashl_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/ashl_datapath.sv
// Datapath of the aged sample history lookup block: history memory, scan and result registers.
module ashl_datapath #(
   parameter int unsigned HISTORY_DEPTH = ashl_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [31:0]          req_sample_value,
   input  logic [31:0]          req_timestamp,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic                 rsp_found,
   output logic [31:0]          rsp_past_value,
   input  logic                 csr_wr_en,
   input  logic [31:0]          csr_wr_data,
   input  ashl_pkg::cmd_type    cmd,
   output ashl_pkg::status_type status
);

   localparam int unsigned IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(HISTORY_DEPTH);

   // Each entry holds the timestamp in the upper half and the value in the lower half.
   logic [63:0] mem [HISTORY_DEPTH];

   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic             full_ff, full_in;
   logic [31:0]      min_age_ff;
   logic [31:0]      now_ff;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [63:0]      rd_ff;
   logic             res_found_ff;
   logic [31:0]      res_value_ff;
   logic             rsp_valid_ff;
   logic             rsp_found_ff;
   logic [31:0]      rsp_value_ff;
   logic [31:0]      age;

   function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] pos);
      return (pos == '0) ? LAST_IDX : pos - IDX_W'(1);
   endfunction

   // History memory: one write port for pushes, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_idx_ff] <= {req_timestamp, req_sample_value};
      end
      rd_ff <= mem[pos_ff];
   end

   // Write index and fill flag.
   always_comb begin
      wr_idx_in = wr_idx_ff;
      full_in   = full_ff;
      if (cmd.push) begin
         if (wr_idx_ff == LAST_IDX) begin
            wr_idx_in = '0;
            full_in   = 1'b1;
         end else begin
            wr_idx_in = wr_idx_ff + IDX_W'(1);
         end
      end
   end

   // Scan address, remaining entry count and read-data valid flag.
   always_comb begin
      pos_in    = pos_ff;
      left_in   = left_ff;
      rd_vld_in = 1'b0;
      if (cmd.start_query) begin
         pos_in  = step_back(wr_idx_ff);
         left_in = full_ff ? FULL_CNT : CNT_W'(wr_idx_ff);
      end else if (cmd.scan && (left_ff != '0)) begin
         pos_in    = step_back(pos_ff);
         left_in   = left_ff - CNT_W'(1);
         rd_vld_in = 1'b1;
      end
   end

   // Age of the entry just read, modulo 2^32.
   assign age = now_ff - rd_ff[63:32];

   assign status.hit       = rd_vld_ff && (age >= min_age_ff);
   assign status.scan_over = !rd_vld_ff && (left_ff == '0);
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff    <= '0;
         full_ff      <= 1'b0;
         min_age_ff   <= ashl_pkg::MIN_AGE_RESET;
         left_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         full_ff   <= full_in;
         left_ff   <= left_in;
         rd_vld_ff <= rd_vld_in;
         if (csr_wr_en) begin
            min_age_ff <= csr_wr_data;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: scan position, query time and result words.
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (cmd.start_query) begin
         now_ff <= req_timestamp;
      end
      if (cmd.capture_hit) begin
         res_found_ff <= 1'b1;
         res_value_ff <= rd_ff[31:0];
      end else if (cmd.capture_miss) begin
         res_found_ff <= 1'b0;
         res_value_ff <= '0;
      end
      if (cmd.load_rsp) begin
         rsp_found_ff <= res_found_ff;
         rsp_value_ff <= res_value_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_past_value = rsp_value_ff;

endmodule

// File: hdl/aged_sample_history_lookup_core.sv
// Top level of the aged sample history lookup block.
//
// Ring buffer of timestamped samples with a lookup of the newest sample at least min_age old.
// A push word gives no response. A query word scans backwards from the newest entry through
// the history memory, one entry per cycle through its single registered read port. It
// occupies the block until its result is loaded into the response register, which waits
// while an earlier response word has not been taken. The response word sits in an output
// register; no new request word is taken during a scan. Unwritten entries are never visited,
// so the memory needs no clearing after reset.
module aged_sample_history_lookup_core #(
   parameter int unsigned HISTORY_DEPTH = ashl_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [31:0] req_sample_value,
   input  logic [31:0] req_timestamp,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [31:0] rsp_past_value,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   ashl_pkg::cmd_type    cmd;
   ashl_pkg::status_type status;

   // Controller.
   ashl_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   // Datapath.
   ashl_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_sample_value (req_sample_value),
      .req_timestamp    (req_timestamp),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_past_value   (rsp_past_value),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .cmd              (cmd),
      .status           (status)
   );

   // A response word that reports no sample carries a zero value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_past_value == '0))
      else $error("response without a sample carries a nonzero value");

   // An accepted query word starts a scan, during which no request word is taken.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_operation == ashl_pkg::OP_QUERY)) |=> !req_ready)
      else $error("request taken right after a query started");

   // Loading the response register always presents a response word.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid)
      else $error("response load did not raise rsp_valid");

endmodule

// File: dv/aged_sample_history_lookup_core_tb.sv
// Self-checking testbench for the aged sample history lookup core.
`timescale 1ns / 100ps

module aged_sample_history_lookup_core_tb;

   localparam int unsigned DEPTH        = 64;
   // A query can hold the block for a full scan of the history; allow some margin on top.
   localparam int unsigned SETTLE_CYCLES = 4 + DEPTH + 8;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned CYCLE_LIMIT   = 2000000;
   localparam int unsigned PHASE_WORDS   = 155;

   // One lookup result as the block should return it.
   typedef struct {
      logic        found;
      logic [31:0] past_value;
   } lookup_result_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic        req_operation    = ashl_pkg::OP_PUSH;
   logic [31:0] req_sample_value = '0;
   logic [31:0] req_timestamp    = '0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic        rsp_found;
   logic [31:0] rsp_past_value;
   logic        csr_wr_en        = 1'b0;
   logic [31:0] csr_wr_data      = '0;

   // Predicted history contents and the minimum age register.
   logic [31:0] hist_value [DEPTH];
   logic [31:0] hist_time  [DEPTH];
   int unsigned hist_wr_ptr;
   logic        hist_full;
   logic [31:0] model_min_age;

   lookup_result_type pending_lookups [$];
   lookup_result_type oldest_lookup;

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_taken   = 0;
   int unsigned hold_left     = 0;
   logic [31:0] now_ms;

   aged_sample_history_lookup_core #(
      .HISTORY_DEPTH(DEPTH)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_sample_value(req_sample_value),
      .req_timestamp   (req_timestamp),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_past_value  (rsp_past_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Guard against a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL aged_sample_history_lookup_core");
         $finish;
      end
   end

   // Result receiver: random stalls, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_requests != holds_taken) begin
         holds_taken = hold_requests;
         hold_left   = HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each accepted result word with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_lookups.size() == 0) begin
            $error("unexpected result word: found %b, past_value %h",
                   rsp_found, rsp_past_value);
            error_count++;
         end else begin
            oldest_lookup = pending_lookups.pop_front();
            if (rsp_found !== oldest_lookup.found) begin
               $error("found mismatch: expected %b, actual %b",
                      oldest_lookup.found, rsp_found);
               error_count++;
            end
            if (rsp_past_value !== oldest_lookup.past_value) begin
               $error("past_value mismatch: expected %h, actual %h",
                      oldest_lookup.past_value, rsp_past_value);
               error_count++;
            end
         end
      end
   end

   // Apply one accepted word to the predicted history; a query yields a lookup result.
   function automatic void apply_word_to_history(input logic op, input logic [31:0] val,
                                                 input logic [31:0] ts);
      lookup_result_type res;
      int unsigned       filled;
      int unsigned       pos;
      logic [31:0]       age;
      if (op == ashl_pkg::OP_PUSH) begin
         hist_value[hist_wr_ptr] = val;
         hist_time[hist_wr_ptr]  = ts;
         if (hist_wr_ptr == DEPTH - 1) begin
            hist_wr_ptr = 0;
            hist_full   = 1'b1;
         end else begin
            hist_wr_ptr = hist_wr_ptr + 1;
         end
         return;
      end
      res.found      = 1'b0;
      res.past_value = '0;
      filled = hist_full ? DEPTH : hist_wr_ptr;
      pos    = hist_wr_ptr;
      // Walk back from the newest entry and stop at the first one old enough.
      for (int unsigned i = 0; i < filled; i++) begin
         pos = (pos == 0) ? DEPTH - 1 : pos - 1;
         age = ts - hist_time[pos];
         if (age >= model_min_age) begin
            res.found      = 1'b1;
            res.past_value = hist_value[pos];
            break;
         end
      end
      pending_lookups.push_back(res);
   endfunction

   // Offer one request word, with random sender gaps, and predict it on acceptance.
   task automatic offer_word(input logic op, input logic [31:0] val, input logic [31:0] ts);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_sample_value <= val;
      req_timestamp    <= ts;
      do @(posedge clock); while (!req_ready);
      apply_word_to_history(op, val, ts);
   endtask

   // Random word: mostly a steadily advancing clock, sometimes an arbitrary timestamp.
   task automatic offer_timed_word(input bit noise);
      logic        op;
      logic [31:0] ts;
      op = ($urandom_range(99) < 40) ? ashl_pkg::OP_QUERY : ashl_pkg::OP_PUSH;
      if (noise) begin
         ts = $urandom;
      end else begin
         now_ms = now_ms + $urandom_range(20, 200);
         ts     = now_ms;
      end
      offer_word(op, $urandom, ts);
   endtask

   // Stop offering, wait for every result and let any last push settle.
   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the minimum age register; only called while the block is idle.
   task automatic write_min_age(input logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      model_min_age = value;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Queries on an empty history under the reset minimum age.
   task automatic test_empty_history();
      offer_word(ashl_pkg::OP_QUERY, $urandom, 32'h0000_0000);
      offer_word(ashl_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   // Samples just under and just over the reset threshold, and none old enough.
   task automatic test_age_threshold();
      offer_word(ashl_pkg::OP_PUSH, 32'h0000_0000, 32'd0);
      offer_word(ashl_pkg::OP_PUSH, 32'hFFFF_FFFF, 32'd1000);
      offer_word(ashl_pkg::OP_QUERY, $urandom, 32'd5999);
      offer_word(ashl_pkg::OP_QUERY, $urandom, 32'd6000);
      offer_word(ashl_pkg::OP_QUERY, $urandom, 32'd1001);
      drain_block();
   endtask

   // Minimum age of zero, all ones, and one across the timestamp wrap.
   task automatic test_min_age_extremes();
      write_min_age(32'h0000_0000);
      offer_word(ashl_pkg::OP_QUERY, $urandom, 32'd1000);
      offer_word(ashl_pkg::OP_PUSH, 32'h1234_5678, 32'd1000);
      offer_word(ashl_pkg::OP_QUERY, $urandom, 32'd1000);
      drain_block();
      write_min_age(32'hFFFF_FFFF);
      offer_word(ashl_pkg::OP_PUSH, 32'hA5A5_A5A5, 32'd1);
      offer_word(ashl_pkg::OP_QUERY, $urandom, 32'd0);
      offer_word(ashl_pkg::OP_QUERY, $urandom, 32'd1000);
      drain_block();
      write_min_age(32'd1);
      offer_word(ashl_pkg::OP_PUSH, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
      offer_word(ashl_pkg::OP_QUERY, $urandom, 32'hFFFF_FFFF);
      offer_word(ashl_pkg::OP_QUERY, $urandom, 32'h0000_0000);
      drain_block();
   endtask

   // Random traffic over several minimum ages and idling patterns.
   task automatic test_random_traffic();
      logic [31:0] age_choice;
      for (int phase = 0; phase < 9; phase++) begin
         case (phase / 3)
            0: begin
               send_idle_pct = 25;
               recv_idle_pct = 71;
            end
            1: begin
               send_idle_pct = 71;
               recv_idle_pct = 25;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (phase)
            0: age_choice = 32'd0;
            1: age_choice = 32'd5000;
            2: age_choice = 32'hFFFF_FFFF;
            3: age_choice = 32'd300;
            4: age_choice = $urandom_range(50, 8000);
            5: age_choice = 32'd1;
            6: age_choice = $urandom;
            7: age_choice = 32'd2000;
            default: age_choice = $urandom_range(0, 12000);
         endcase
         write_min_age(age_choice);
         // Start some phases close to the end of the millisecond counter.
         if (phase == 4 || phase == 7)
            now_ms = 32'hFFFF_F000 + $urandom_range(0, 255);
         for (int n = 0; n < PHASE_WORDS; n++)
            offer_timed_word($urandom_range(99) < 15);
         drain_block();
      end
   endtask

   // Hold off the receiver for a long stretch while words keep coming.
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_min_age(32'd500);
      hold_requests = hold_requests + 1;
      for (int n = 0; n < 40; n++)
         offer_word((n % 3 == 2) ? ashl_pkg::OP_QUERY : ashl_pkg::OP_PUSH, $urandom,
                    now_ms + 32'd100 * n);
      now_ms = now_ms + 32'd4000;
      drain_block();
   endtask

   // Test sequence.
   initial begin
      hist_wr_ptr   = 0;
      hist_full     = 1'b0;
      model_min_age = ashl_pkg::MIN_AGE_RESET;
      now_ms        = $urandom;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_history();
      test_age_threshold();
      test_min_age_extremes();
      test_output_backpressure();
      test_random_traffic();

      drain_block();
      if (error_count == 0) begin
         $display("PASS aged_sample_history_lookup_core");
      end else begin
         $display("FAIL aged_sample_history_lookup_core");
      end
      $finish;
   end

endmodule
